FILE: rtl/core/cfae_pkg.sv
// shared types, character codes and the verb table for the command frame ack engine
// no dependencies; every other file but cfae_ram refers to it by scoped names
package cfae_pkg;

    localparam int NumVerbs   = 6;
    localparam int MaxVerbLen = 4;
    localparam int ReplyExtra = 6;
    localparam int ItemW      = 11;
    localparam int ItemBytesW = 16;
    localparam int ResultW    = 169;
    localparam int ResBytesW  = 176;
    localparam int CfgIdxW    = 2;

    localparam logic [7:0] ChNul   = 8'd0;
    localparam logic [7:0] ChTab   = 8'd9;
    localparam logic [7:0] ChSpace = 8'd32;
    localparam logic [7:0] ChA     = 8'h61;
    localparam logic [7:0] ChC     = 8'h63;
    localparam logic [7:0] ChK     = 8'h6b;

    // verbs, padded with nul; chnm ud sw sel sett md
    localparam logic [7:0] VerbChars [NumVerbs][MaxVerbLen] = '{
        '{8'h63, 8'h68, 8'h6e, 8'h6d},
        '{8'h75, 8'h64, 8'h00, 8'h00},
        '{8'h73, 8'h77, 8'h00, 8'h00},
        '{8'h73, 8'h65, 8'h6c, 8'h00},
        '{8'h73, 8'h65, 8'h74, 8'h74},
        '{8'h6d, 8'h64, 8'h00, 8'h00}
    };
    localparam logic [2:0] VerbLen [NumVerbs] = '{3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd2};

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FRAME_OPEN  = 2'd0,
        CFG_FRAME_CLOSE = 2'd1,
        CFG_REPLY_OPEN  = 2'd2,
        CFG_REPLY_CLOSE = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_VRD,
        ST_VCHK,
        ST_RES,
        ST_HDR,
        ST_BODY,
        ST_TAIL,
        ST_TX,
        ST_TXD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] reply_close;
        logic [7:0] reply_open;
        logic [7:0] frame_close;
        logic [7:0] frame_open;
    } t_cfg;

    typedef struct packed {
        logic       send_ready;
        logic [7:0] byte_in;
        logic       byte_valid;
        logic       overrun_seen;
    } t_item;

    typedef struct packed {
        logic [31:0] dropped_count;
        logic [31:0] overrun_count;
        logic [31:0] unknown_count;
        logic [31:0] frames_count;
        logic [31:0] bytes_count;
        logic [7:0]  send_byte;
        logic        send_valid;
    } t_result;

    function automatic logic is_delim(input logic [7:0] b);
        return (b == ChNul) || (b == ChSpace) || (b == ChTab);
    endfunction

    // verbs whose char at position pos equals b
    function automatic logic [NumVerbs-1:0] char_match(input logic [1:0] pos,
                                                       input logic [7:0] b);
        logic [NumVerbs-1:0] m;
        for (int v = 0; v < NumVerbs; v++) begin
            m[v] = (VerbChars[v][pos] == b);
        end
        return m;
    endfunction

    // a word of length wlen is known if a still matching verb has that length
    function automatic logic known_at(input logic [NumVerbs-1:0] mask,
                                      input logic [2:0] wlen);
        logic k;
        k = 1'b0;
        for (int v = 0; v < NumVerbs; v++) begin
            k = k | (mask[v] && (VerbLen[v] == wlen));
        end
        return k;
    endfunction

endpackage

FILE: rtl/core/command_frame_ack_engine.sv
// command frame ack engine: one result per item; an item updates frame state and counters and may
// read one ring byte, then its result enters the output register; a closing known frame first scans
// its verb a char at a time over the frame store read port, then writes the reply into the ring one
// byte a cycle; s_axis_tready is high again in the cycle after a result enters the output register
// synchronous active-low reset clears the counters, ring pointers and frame state and
// restores the default delimiters; depends on cfae_pkg, cfae_ctrl and cfae_ram
module command_frame_ack_engine #(
    parameter int FRAME_MAX  = 64,
    parameter int RING_DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // overrun_seen, byte_valid, byte_in[7:0], send_ready, zero fill
    input  logic [cfae_pkg::ItemBytesW-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // send_valid, send_byte[7:0], bytes_count, frames_count, unknown_count,
    // overrun_count, dropped_count (32 each), zero fill
    output logic [cfae_pkg::ResBytesW-1:0]    m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [cfae_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [7:0]                        i_cfg_data
);

    localparam int FAW = $clog2(FRAME_MAX);
    localparam int PW  = $clog2(RING_DEPTH);

    cfae_pkg::t_cfg    r_cfg, n_cfg;
    logic              r_m_valid, n_m_valid;
    cfae_pkg::t_result r_m_data, n_m_data;

    logic              accept;
    logic              slot_free;
    logic              done;
    cfae_pkg::t_result result;
    cfae_pkg::t_item   item;

    logic           fr_we, fr_re;
    logic [FAW-1:0] fr_waddr, fr_raddr;
    logic [7:0]     fr_wdata, fr_rdata;
    logic           ring_we, ring_re;
    logic [PW-1:0]  ring_waddr, ring_raddr;
    logic [7:0]     ring_wdata, ring_rdata;

    assign item      = cfae_pkg::t_item'(s_axis_tdata[cfae_pkg::ItemW-1:0]);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign slot_free = !r_m_valid || m_axis_tready;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                cfae_pkg::CFG_FRAME_OPEN:  n_cfg.frame_open  = i_cfg_data;
                cfae_pkg::CFG_FRAME_CLOSE: n_cfg.frame_close = i_cfg_data;
                cfae_pkg::CFG_REPLY_OPEN:  n_cfg.reply_open  = i_cfg_data;
                cfae_pkg::CFG_REPLY_CLOSE: n_cfg.reply_close = i_cfg_data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    // output register holds a finished result while the next item is worked on
    always_comb begin
        n_m_data  = r_m_data;
        n_m_valid = r_m_valid;
        if (done) begin
            n_m_data  = result;
            n_m_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_open  <= 8'd37;
            r_cfg.frame_close <= 8'd37;
            r_cfg.reply_open  <= 8'd36;
            r_cfg.reply_close <= 8'd94;
            r_m_valid         <= 1'b0;
        end else begin
            r_cfg     <= n_cfg;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(cfae_pkg::ResBytesW - cfae_pkg::ResultW){1'b0}}, r_m_data};

    cfae_ctrl #(
        .FRAME_MAX  (FRAME_MAX),
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (item),
        .i_cfg        (r_cfg),
        .i_slot_free  (slot_free),
        .o_ready      (s_axis_tready),
        .o_done       (done),
        .o_result     (result),
        .o_fr_we      (fr_we),
        .o_fr_waddr   (fr_waddr),
        .o_fr_wdata   (fr_wdata),
        .o_fr_re      (fr_re),
        .o_fr_raddr   (fr_raddr),
        .i_fr_rdata   (fr_rdata),
        .o_ring_we    (ring_we),
        .o_ring_waddr (ring_waddr),
        .o_ring_wdata (ring_wdata),
        .o_ring_re    (ring_re),
        .o_ring_raddr (ring_raddr),
        .i_ring_rdata (ring_rdata)
    );

    cfae_ram #(
        .DEPTH (FRAME_MAX),
        .AW    (FAW)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (fr_waddr),
        .i_wdata (fr_wdata),
        .i_re    (fr_re),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    cfae_ram #(
        .DEPTH (RING_DEPTH),
        .AW    (PW)
    ) u_reply_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

endmodule

FILE: rtl/core/cfae_ram.sv
// single port write, single port read byte memory with registered read data
// used for the frame store and the reply ring; no package dependency
module cfae_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/cfae_ctrl.sv
// item sequencer: frame capture, verb match, reply copy into the ring, ring drain, counters
// depends on cfae_pkg; drives the ports of the frame store and reply ring memories
module cfae_ctrl #(
    parameter int FRAME_MAX  = 64,
    parameter int RING_DEPTH = 256,
    localparam int FAW = $clog2(FRAME_MAX),
    localparam int LW  = $clog2(FRAME_MAX + 1),
    localparam int PW  = $clog2(RING_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  cfae_pkg::t_item    i_item,
    input  cfae_pkg::t_cfg     i_cfg,
    input  logic               i_slot_free,
    output logic               o_ready,
    output logic               o_done,
    output cfae_pkg::t_result  o_result,
    output logic               o_fr_we,
    output logic [FAW-1:0]     o_fr_waddr,
    output logic [7:0]         o_fr_wdata,
    output logic               o_fr_re,
    output logic [FAW-1:0]     o_fr_raddr,
    input  logic [7:0]         i_fr_rdata,
    output logic               o_ring_we,
    output logic [PW-1:0]      o_ring_waddr,
    output logic [7:0]         o_ring_wdata,
    output logic               o_ring_re,
    output logic [PW-1:0]      o_ring_raddr,
    input  logic [7:0]         i_ring_rdata
);

    localparam int SW = (PW + 1 > 9) ? PW + 1 : 9;

    cfae_pkg::t_state  r_state, n_state;
    cfae_pkg::t_item   r_item, n_item;
    cfae_pkg::t_result r_res, n_res;
    logic                          r_inside, n_inside;
    logic [LW-1:0]                 r_len, n_len;
    logic [PW-1:0]                 r_wr, n_wr;
    logic [PW-1:0]                 r_rd, n_rd;
    logic [2:0]                    r_k, n_k;
    logic [cfae_pkg::NumVerbs-1:0] r_mask, n_mask;
    logic                          r_known, n_known;
    logic [2:0]                    r_j, n_j;
    logic [FAW-1:0]                r_i, n_i;

    logic          eff_inside;
    logic [LW-1:0] eff_len;
    logic          step_store;
    logic [PW-1:0] wr_inc;
    logic [PW-1:0] rd_inc;
    logic [SW-1:0] space;
    logic [SW-1:0] need;
    logic          ring_has_data;
    logic          k_at_end;
    logic          body_more;

    // an overrun in the same item drops the partial frame before the byte is seen
    assign eff_inside = r_inside && !r_item.overrun_seen;
    assign eff_len    = r_item.overrun_seen ? '0 : r_len;
    assign step_store = r_item.byte_valid && eff_inside
                        && (r_item.byte_in != i_cfg.frame_close)
                        && (eff_len < LW'(FRAME_MAX));

    assign wr_inc = (r_wr == PW'(RING_DEPTH - 1)) ? '0 : r_wr + PW'(1);
    assign rd_inc = (r_rd == PW'(RING_DEPTH - 1)) ? '0 : r_rd + PW'(1);
    assign space  = (r_rd > r_wr) ? SW'(r_rd) - SW'(r_wr) - SW'(1)
                                  : SW'(r_rd) + SW'(RING_DEPTH) - SW'(r_wr) - SW'(1);
    assign need   = SW'(r_len) + SW'(cfae_pkg::ReplyExtra);
    assign ring_has_data = (r_rd != r_wr);
    assign k_at_end      = (LW'(r_k) == r_len);
    assign body_more     = ((LW'(r_i) + LW'(1)) < r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cfae_pkg::ST_IDLE;
            r_inside <= 1'b0;
            r_len    <= '0;
            r_wr     <= '0;
            r_rd     <= '0;
            r_res    <= '0;
        end else begin
            r_state  <= n_state;
            r_inside <= n_inside;
            r_len    <= n_len;
            r_wr     <= n_wr;
            r_rd     <= n_rd;
            r_res    <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_k     <= n_k;
        r_mask  <= n_mask;
        r_known <= n_known;
        r_j     <= n_j;
        r_i     <= n_i;
    end

    // next state and datapath
    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_res    = r_res;
        n_inside = r_inside;
        n_len    = r_len;
        n_wr     = r_wr;
        n_rd     = r_rd;
        n_k      = r_k;
        n_mask   = r_mask;
        n_known  = r_known;
        n_j      = r_j;
        n_i      = r_i;
        case (r_state)
            cfae_pkg::ST_IDLE: begin
                if (i_accept) begin
                    n_item  = i_item;
                    n_state = cfae_pkg::ST_STEP;
                end
            end
            cfae_pkg::ST_STEP: begin
                n_state = cfae_pkg::ST_TX;
                if (r_item.overrun_seen) begin
                    n_res.overrun_count = r_res.overrun_count + 32'd1;
                    n_inside = 1'b0;
                    n_len    = '0;
                end
                if (r_item.byte_valid) begin
                    n_res.bytes_count = r_res.bytes_count + 32'd1;
                    if (!eff_inside) begin
                        if (r_item.byte_in == i_cfg.frame_open) begin
                            n_inside = 1'b1;
                            n_len    = '0;
                        end
                    end else if (r_item.byte_in == i_cfg.frame_close) begin
                        n_inside = 1'b0;
                        if (eff_len != '0) begin
                            n_k     = 3'd0;
                            n_mask  = '1;
                            n_state = cfae_pkg::ST_VRD;
                        end
                    end else if (!step_store) begin
                        // frame too long: abandon and wait for a new open char
                        n_inside = 1'b0;
                        n_len    = '0;
                    end else begin
                        n_len = eff_len + LW'(1);
                    end
                end
            end
            cfae_pkg::ST_VRD: begin
                if (k_at_end) begin
                    n_known = cfae_pkg::known_at(r_mask, r_k);
                    n_state = cfae_pkg::ST_RES;
                end else begin
                    n_state = cfae_pkg::ST_VCHK;
                end
            end
            cfae_pkg::ST_VCHK: begin
                if (cfae_pkg::is_delim(i_fr_rdata)) begin
                    n_known = cfae_pkg::known_at(r_mask, r_k);
                    n_state = cfae_pkg::ST_RES;
                end else if (r_k == 3'(cfae_pkg::MaxVerbLen)) begin
                    // word longer than any verb
                    n_known = 1'b0;
                    n_state = cfae_pkg::ST_RES;
                end else begin
                    n_mask  = r_mask & cfae_pkg::char_match(r_k[1:0], i_fr_rdata);
                    n_k     = r_k + 3'd1;
                    n_state = cfae_pkg::ST_VRD;
                end
            end
            cfae_pkg::ST_RES: begin
                n_state = cfae_pkg::ST_TX;
                if (!r_known) begin
                    n_res.unknown_count = r_res.unknown_count + 32'd1;
                end else begin
                    n_res.frames_count = r_res.frames_count + 32'd1;
                    if (need > space) begin
                        n_res.dropped_count = r_res.dropped_count + 32'd1;
                    end else begin
                        n_j     = 3'd0;
                        n_state = cfae_pkg::ST_HDR;
                    end
                end
            end
            cfae_pkg::ST_HDR: begin
                n_wr = wr_inc;
                if (r_j == 3'd4) begin
                    n_i     = '0;
                    n_state = cfae_pkg::ST_BODY;
                end else begin
                    n_j = r_j + 3'd1;
                end
            end
            cfae_pkg::ST_BODY: begin
                n_wr = wr_inc;
                if (body_more) begin
                    n_i = r_i + FAW'(1);
                end else begin
                    n_state = cfae_pkg::ST_TAIL;
                end
            end
            cfae_pkg::ST_TAIL: begin
                n_wr    = wr_inc;
                n_state = cfae_pkg::ST_TX;
            end
            cfae_pkg::ST_TX: begin
                if (r_item.send_ready && ring_has_data) begin
                    n_rd    = rd_inc;
                    n_state = cfae_pkg::ST_TXD;
                end else begin
                    n_res.send_valid = 1'b0;
                    n_res.send_byte  = 8'd0;
                    n_state          = cfae_pkg::ST_DONE;
                end
            end
            cfae_pkg::ST_TXD: begin
                n_res.send_valid = 1'b1;
                n_res.send_byte  = i_ring_rdata;
                n_state          = cfae_pkg::ST_DONE;
            end
            cfae_pkg::ST_DONE: begin
                if (i_slot_free) begin
                    n_state = cfae_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cfae_pkg::ST_IDLE;
            end
        endcase
    end

    // memory ports and handshake
    always_comb begin
        o_ready      = (r_state == cfae_pkg::ST_IDLE);
        o_done       = (r_state == cfae_pkg::ST_DONE) && i_slot_free;
        o_fr_we      = (r_state == cfae_pkg::ST_STEP) && step_store;
        o_fr_waddr   = FAW'(eff_len);
        o_fr_wdata   = r_item.byte_in;
        o_fr_re      = 1'b0;
        o_fr_raddr   = '0;
        o_ring_we    = 1'b0;
        o_ring_waddr = r_wr;
        o_ring_wdata = i_cfg.reply_close;
        o_ring_re    = 1'b0;
        o_ring_raddr = r_rd;
        case (r_state)
            cfae_pkg::ST_VRD: begin
                o_fr_re    = !k_at_end;
                o_fr_raddr = FAW'(r_k);
            end
            cfae_pkg::ST_HDR: begin
                o_ring_we = 1'b1;
                // fetch the first frame byte while the last header byte goes out
                o_fr_re   = (r_j == 3'd4);
                case (r_j)
                    3'd0:    o_ring_wdata = i_cfg.reply_open;
                    3'd1:    o_ring_wdata = cfae_pkg::ChA;
                    3'd2:    o_ring_wdata = cfae_pkg::ChC;
                    3'd3:    o_ring_wdata = cfae_pkg::ChK;
                    default: o_ring_wdata = cfae_pkg::ChSpace;
                endcase
            end
            cfae_pkg::ST_BODY: begin
                o_ring_we    = 1'b1;
                o_ring_wdata = i_fr_rdata;
                o_fr_re      = body_more;
                o_fr_raddr   = r_i + FAW'(1);
            end
            cfae_pkg::ST_TAIL: begin
                o_ring_we = 1'b1;
            end
            cfae_pkg::ST_TX: begin
                o_ring_re = r_item.send_ready && ring_has_data;
            end
            default: begin
            end
        endcase
    end

    assign o_result = r_res;

endmodule

FILE: tb/sv/tb.sv
// testbench for command_frame_ack_engine: random and directed byte streams, checked result by result
// depends on cfae_pkg and the command_frame_ack_engine rtl
`timescale 1ns / 1ps

module tb;

    localparam int FRAME_MAX  = 64;
    localparam int RING_DEPTH = 256;

    // tracks frame, ring and counter state and holds the results still to come
    class frame_ack_tracker;
        logic [7:0]  open_ch, close_ch, rep_open, rep_close;
        logic [7:0]  frame_buf [FRAME_MAX];
        int unsigned frame_len;
        bit          collecting;
        logic [7:0]  ring [RING_DEPTH];
        int unsigned wr_pos, rd_pos;
        logic [31:0] n_bytes, n_frames, n_unknown, n_overrun, n_dropped;
        string       verbs [6];
        cfae_pkg::t_result pending_results [$];
        int          errors, checked, items, sent;

        function new();
            verbs[0] = "chnm";
            verbs[1] = "ud";
            verbs[2] = "sw";
            verbs[3] = "sel";
            verbs[4] = "sett";
            verbs[5] = "md";
            open_ch    = 8'd37;
            close_ch   = 8'd37;
            rep_open   = 8'd36;
            rep_close  = 8'd94;
            frame_len  = 0;
            collecting = 1'b0;
            wr_pos     = 0;
            rd_pos     = 0;
            n_bytes    = '0;
            n_frames   = '0;
            n_unknown  = '0;
            n_overrun  = '0;
            n_dropped  = '0;
            errors     = 0;
            checked    = 0;
            items      = 0;
            sent       = 0;
        endfunction

        function string verb(int i);
            return verbs[i];
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void write_reg(cfae_pkg::t_cfg_idx idx, logic [7:0] val);
            case (idx)
                cfae_pkg::CFG_FRAME_OPEN:  open_ch   = val;
                cfae_pkg::CFG_FRAME_CLOSE: close_ch  = val;
                cfae_pkg::CFG_REPLY_OPEN:  rep_open  = val;
                cfae_pkg::CFG_REPLY_CLOSE: rep_close = val;
                default: ;
            endcase
        endfunction

        function bit verb_known();
            int unsigned w;
            bit          hit;
            w = 0;
            while (w < frame_len && frame_buf[w] != 8'd0 && frame_buf[w] != 8'd32
                   && frame_buf[w] != 8'd9)
                w++;
            if (w == 0) return 1'b0;
            for (int i = 0; i < 6; i++) begin
                if (verbs[i].len() == w) begin
                    hit = 1'b1;
                    for (int k = 0; k < w; k++)
                        if (frame_buf[k] != verbs[i][k]) hit = 1'b0;
                    if (hit) return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void ring_put(logic [7:0] b);
            ring[wr_pos] = b;
            wr_pos = (wr_pos + 1) % RING_DEPTH;
        endfunction

        function void close_frame();
            int unsigned space;
            if (frame_len == 0) return;
            if (!verb_known()) begin
                n_unknown++;
                return;
            end
            n_frames++;
            space = (rd_pos + RING_DEPTH - wr_pos - 1) % RING_DEPTH;
            if (frame_len + 6 > space) begin
                n_dropped++;
                return;
            end
            ring_put(rep_open);
            ring_put("a");
            ring_put("c");
            ring_put("k");
            ring_put(8'd32);
            for (int i = 0; i < frame_len; i++) ring_put(frame_buf[i]);
            ring_put(rep_close);
        endfunction

        function void predict_item(cfae_pkg::t_item it);
            cfae_pkg::t_result r;
            items++;
            if (it.overrun_seen) begin
                n_overrun++;
                collecting = 1'b0;
                frame_len  = 0;
            end
            if (it.byte_valid) begin
                n_bytes++;
                if (!collecting) begin
                    if (it.byte_in == open_ch) begin
                        collecting = 1'b1;
                        frame_len  = 0;
                    end
                end else if (it.byte_in == close_ch) begin
                    collecting = 1'b0;
                    close_frame();
                end else if (frame_len >= FRAME_MAX) begin
                    // over-long frame is abandoned, the byte is lost
                    collecting = 1'b0;
                    frame_len  = 0;
                end else begin
                    frame_buf[frame_len] = it.byte_in;
                    frame_len++;
                end
            end
            r = '0;
            if (it.send_ready && rd_pos != wr_pos) begin
                r.send_valid = 1'b1;
                r.send_byte  = ring[rd_pos];
                rd_pos = (rd_pos + 1) % RING_DEPTH;
                sent++;
            end
            r.bytes_count   = n_bytes;
            r.frames_count  = n_frames;
            r.unknown_count = n_unknown;
            r.overrun_count = n_overrun;
            r.dropped_count = n_dropped;
            pending_results.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(cfae_pkg::t_result act);
            cfae_pkg::t_result exp_r;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", act);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            checked++;
            check_field("send_valid", exp_r.send_valid, act.send_valid);
            check_field("send_byte", exp_r.send_byte, act.send_byte);
            check_field("bytes_count", exp_r.bytes_count, act.bytes_count);
            check_field("frames_count", exp_r.frames_count, act.frames_count);
            check_field("unknown_count", exp_r.unknown_count, act.unknown_count);
            check_field("overrun_count", exp_r.overrun_count, act.overrun_count);
            check_field("dropped_count", exp_r.dropped_count, act.dropped_count);
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [cfae_pkg::ItemBytesW-1:0] s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [cfae_pkg::ResBytesW-1:0]  m_axis_tdata;
    logic                            i_cfg_we;
    logic [cfae_pkg::CfgIdxW-1:0]    i_cfg_index;
    logic [7:0]                      i_cfg_data;

    frame_ack_tracker tracker = new();
    int  burst_left    = 0;
    int  byte_items    = 0;
    int  cfg_settings  = 0;
    bit  long_hold_req = 1'b0;

    command_frame_ack_engine #(
        .FRAME_MAX  (FRAME_MAX),
        .RING_DEPTH (RING_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    // receiver: rotating stall pattern, plus one long hold-off on request
    initial begin : receiver
        int unsigned rx_cyc;
        int          hold_left;
        rx_cyc = 0;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cyc++;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case ((rx_cyc / 150) % 4)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= (rx_cyc % 5 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid && m_axis_tready)
            tracker.check_result(cfae_pkg::t_result'(m_axis_tdata[cfae_pkg::ResultW-1:0]));
    end

    // sender works in bursts with random gaps in between
    task automatic offer_item(cfae_pkg::t_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {{(cfae_pkg::ItemBytesW - cfae_pkg::ItemW){1'b0}}, it};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.predict_item(it);
    endtask

    task automatic emit(bit ovr, bit bv, logic [7:0] b, int rdy_pct);
        cfae_pkg::t_item it;
        it.overrun_seen = ovr;
        it.byte_valid   = bv;
        it.byte_in      = b;
        it.send_ready   = ($urandom_range(0, 99) < rdy_pct);
        if (bv) byte_items++;
        offer_item(it);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(cfae_pkg::t_cfg_idx idx, logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        tracker.write_reg(idx, val);
    endtask

    task automatic set_chars(logic [7:0] f_open, logic [7:0] f_close,
                             logic [7:0] r_open, logic [7:0] r_close);
        drain_results();
        write_reg(cfae_pkg::CFG_FRAME_OPEN, f_open);
        write_reg(cfae_pkg::CFG_FRAME_CLOSE, f_close);
        write_reg(cfae_pkg::CFG_REPLY_OPEN, r_open);
        write_reg(cfae_pkg::CFG_REPLY_CLOSE, r_close);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_settings++;
    endtask

    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == tracker.close_ch);
        return b;
    endfunction

    // well-formed frames with random content, plus over-long, broken and noise items
    task automatic random_traffic(int target, int rdy_pct);
        int    kind, wlen, plen, n;
        string w;
        logic [7:0] d;
        target = byte_items + target;
        while (byte_items < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 62) begin
                emit(1'b0, 1'b1, tracker.open_ch, rdy_pct);
                w = tracker.verb($urandom_range(0, 5));
                n = $urandom_range(0, 9);
                if (n == 0) begin
                    w = w.substr(0, w.len() - 2);
                end else if (n == 1) begin
                    w = "";
                    repeat ($urandom_range(1, 5)) w = {w, string'(8'($urandom_range(97, 122)))};
                end
                wlen = w.len();
                for (int i = 0; i < wlen; i++)
                    if (w[i] != tracker.close_ch) emit(1'b0, 1'b1, w[i], rdy_pct);
                if ($urandom_range(0, 9) == 0)
                    plen = FRAME_MAX - wlen - 1 - $urandom_range(0, 4);
                else
                    plen = $urandom_range(0, 10);
                if (plen > 0) begin
                    case ($urandom_range(0, 2))
                        0: d = 8'd32;
                        1: d = 8'd9;
                        default: d = 8'd0;
                    endcase
                    if (d == tracker.close_ch) d = 8'd32;
                    emit(1'b0, 1'b1, d, rdy_pct);
                    repeat (plen) emit(1'b0, 1'b1, data_byte(), rdy_pct);
                end
                emit(1'b0, 1'b1, tracker.close_ch, rdy_pct);
            end else if (kind < 67) begin
                emit(1'b0, 1'b1, tracker.open_ch, rdy_pct);
                repeat (FRAME_MAX + 1 + $urandom_range(0, 2))
                    emit(1'b0, 1'b1, data_byte(), rdy_pct);
                emit(1'b0, 1'b1, tracker.close_ch, rdy_pct);
            end else if (kind < 80) begin
                emit(1'b0, 1'b1, tracker.open_ch, rdy_pct);
                repeat ($urandom_range(0, 5)) emit(1'b0, 1'b1, data_byte(), rdy_pct);
                emit(1'b1, 1'($urandom_range(0, 1)), data_byte(), rdy_pct);
                if ($urandom_range(0, 1) == 1) emit(1'b0, 1'b1, tracker.close_ch, rdy_pct);
            end else begin
                repeat ($urandom_range(1, 4))
                    emit($urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)), rdy_pct);
                // drain-only items
                repeat ($urandom_range(0, 3)) emit(1'b0, 1'b0, 8'd0, 100);
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= cfae_pkg::CFG_FRAME_OPEN;
        i_cfg_data    <= 8'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed, reset delimiters: open and close are both the percent sign
        emit(1'b0, 1'b1, "x", 0);
        emit(1'b0, 1'b1, 8'h25, 0);
        emit(1'b0, 1'b1, "s", 0);
        emit(1'b0, 1'b1, "w", 0);
        emit(1'b0, 1'b1, 8'h25, 0);
        emit(1'b0, 1'b1, 8'h25, 100);   // empty frame
        emit(1'b0, 1'b1, 8'h25, 100);
        emit(1'b0, 1'b1, 8'h25, 100);   // verb ended by a tab
        emit(1'b0, 1'b1, "u", 100);
        emit(1'b0, 1'b1, "d", 100);
        emit(1'b0, 1'b1, 8'h09, 100);
        emit(1'b0, 1'b1, 8'hff, 100);
        emit(1'b0, 1'b1, 8'h25, 100);
        emit(1'b0, 1'b1, 8'h25, 100);   // empty word: leading nul
        emit(1'b0, 1'b1, 8'h00, 100);
        emit(1'b0, 1'b1, "s", 100);
        emit(1'b0, 1'b1, 8'h25, 100);
        emit(1'b0, 1'b1, 8'h25, 0);     // overrun abandons a partial frame
        emit(1'b0, 1'b1, "m", 0);
        emit(1'b1, 1'b0, 8'h00, 0);
        emit(1'b0, 1'b1, "d", 0);
        emit(1'b0, 1'b1, 8'h25, 0);
        emit(1'b1, 1'b1, 8'hff, 100);
        emit(1'b0, 1'b0, 8'h00, 100);

        random_traffic(190, 40);

        set_chars(8'h00, 8'hff, 8'h00, 8'hff);
        random_traffic(280, 70);

        // ring fills up, replies get dropped; receiver also holds off for a while
        set_chars(8'hff, 8'h00, 8'hff, 8'h00);
        long_hold_req = 1'b1;
        random_traffic(280, 15);

        set_chars(8'h3c, 8'h3e, 8'h55, 8'haa);
        random_traffic(125, 50);
        drain_results();
        random_traffic(125, 50);

        set_chars(8'h23, 8'h23, 8'h7e, 8'h0a);
        random_traffic(250, 90);

        drain_results();
        $display("%0d item transfers over %0d delimiter settings, %0d results checked",
                 tracker.items, cfg_settings + 1, tracker.checked);
        $display("acks %0d, dropped %0d, unknown %0d, overruns %0d, bytes sent %0d",
                 tracker.n_frames - tracker.n_dropped, tracker.n_dropped,
                 tracker.n_unknown, tracker.n_overrun, tracker.sent);
        if (tracker.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/cfae_pkg.sv
rtl/core/cfae_ram.sv
rtl/core/cfae_ctrl.sv
rtl/core/command_frame_ack_engine.sv
tb/sv/tb.sv
